// ===== rtl/core/bsrc_pkg.sv =====
`timescale 1ns / 1ps

package bsrc_pkg;

    localparam int RECORDS_PER_BLAST  = 200;
    localparam int RECORDS_PER_PACKET = 16;
    localparam int CMD_QUEUE_DEPTH    = 2;
    localparam int MAX_DATA_PKTS      = 14;
    localparam int PKT_SIZE_MAX       = 16;
    localparam int CFG_DATA_W         = 24;
    localparam int CFG_ADDR_W         = 1;

    localparam logic [23:0] RECORD_TOTAL_RESET = 24'd0;
    localparam logic [7:0]  RETRY_LIMIT_RESET  = 8'd50;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_EMPTY   = 2'd1,
        MODE_MISSING = 2'd2,
        MODE_TIMEOUT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_OVER = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RECORD_TOTAL = 1'b0,
        CFG_RETRY_LIMIT  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_BLAST,
        CMD_OVER,
        CMD_DONE,
        CMD_RESEND
    } t_cmd_kind;

    typedef enum logic {
        PH_IDLE,
        PH_WAIT
    } t_phase;

    typedef enum logic {
        FS_READY,
        FS_LOAD
    } t_front_state;

    typedef enum logic [1:0] {
        BS_FETCH,
        BS_DATA,
        BS_OVER,
        BS_DONE
    } t_back_state;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] missing_index;
        logic       last_entry;
    } t_item;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic [16:0] blast_number;
        logic [3:0]  packet_number;
        logic [23:0] first_record;
        logic [4:0]  records_in_packet;
        logic [4:0]  packets_total;
        logic        bad_index;
        logic        run_last;
    } t_result;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [16:0] blast;
        logic [23:0] first;
        logic [7:0]  count;
        logic [4:0]  pkts;
        logic [3:0]  idx;
        logic        bad;
        logic        with_over;
    } t_cmd;

    function automatic int pkt_size(input int rpp);
        int s;
        s = rpp;
        if (s > PKT_SIZE_MAX) s = PKT_SIZE_MAX;
        if (s < 1) s = 1;
        return s;
    endfunction

    function automatic int blast_cap(input int rpb, input int ps);
        int c;
        c = rpb;
        if (c > MAX_DATA_PKTS * ps) c = MAX_DATA_PKTS * ps;
        if (c < 1) c = 1;
        return c;
    endfunction

endpackage

// ===== rtl/core/bsrc_fifo.sv =====
`timescale 1ns / 1ps

module bsrc_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/bsrc_front.sv =====
`timescale 1ns / 1ps

module bsrc_front #(
    parameter int RECORDS_PER_BLAST  = 200,
    parameter int RECORDS_PER_PACKET = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsrc_pkg::t_item i_item,
    output logic           o_full,
    input  logic [23:0]    i_record_total,
    input  logic [7:0]     i_retry_limit,
    output logic           o_cmd_push,
    output bsrc_pkg::t_cmd o_cmd,
    input  logic           i_cmd_full
);
    import bsrc_pkg::*;

    localparam int          PS    = pkt_size(RECORDS_PER_PACKET);
    localparam int          CAP   = blast_cap(RECORDS_PER_BLAST, PS);
    localparam logic [23:0] CAP24 = 24'(CAP);

    t_front_state r_state, n_state;
    t_phase       r_phase, n_phase;
    logic [16:0]  r_index, n_index;
    logic [23:0]  r_first, n_first;
    logic [7:0]   r_count, n_count;
    logic [4:0]   r_pkts, n_pkts;
    logic [7:0]   r_timeout, n_timeout;

    logic         accept;
    logic         in_wait;
    logic [7:0]   tc;
    logic         retry_again;
    logic         go_load;
    logic         idx_ok;
    logic         ld_done;
    logic [23:0]  ld_left;
    logic [7:0]   ld_cnt;
    logic [4:0]   ld_pkts;

    assign o_full      = (r_state != FS_READY) || i_cmd_full;
    assign accept      = i_push && !o_full;
    assign in_wait     = (r_phase == PH_WAIT);
    assign tc          = r_timeout + 8'd1;
    assign retry_again = (tc < i_retry_limit);
    assign idx_ok      = ({1'b0, i_item.missing_index} < r_pkts);
    assign go_load     = (i_item.mode == MODE_START)
                      || (in_wait && (i_item.mode == MODE_EMPTY))
                      || (in_wait && (i_item.mode == MODE_TIMEOUT) && !retry_again);

    // blast setup from the current first record
    assign ld_done = (r_first >= i_record_total);
    assign ld_left = i_record_total - r_first;
    assign ld_cnt  = (ld_left > CAP24) ? 8'(CAP) : ld_left[7:0];

    always_comb begin
        ld_pkts = '0;
        for (int p = 0; p < MAX_DATA_PKTS; p++) begin
            if (ld_cnt > 8'(p * PS)) ld_pkts = ld_pkts + 5'd1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_READY: if (accept && go_load) n_state = FS_LOAD;
            FS_LOAD:  if (!i_cmd_full) n_state = FS_READY;
            default:  n_state = FS_READY;
        endcase
    end

    // command to the back end
    always_comb begin
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            FS_LOAD: begin
                o_cmd_push      = !i_cmd_full;
                o_cmd.kind      = ld_done ? CMD_DONE : CMD_BLAST;
                o_cmd.blast     = r_index;
                o_cmd.first     = r_first;
                o_cmd.count     = ld_cnt;
                o_cmd.pkts      = ld_pkts;
                o_cmd.with_over = 1'b1;
            end
            FS_READY: begin
                o_cmd.blast = r_index;
                o_cmd.first = r_first;
                o_cmd.count = r_count;
                o_cmd.pkts  = r_pkts;
                if (accept && in_wait && (i_item.mode == MODE_MISSING)) begin
                    o_cmd_push      = 1'b1;
                    o_cmd.kind      = CMD_RESEND;
                    o_cmd.idx       = i_item.missing_index;
                    o_cmd.bad       = !idx_ok;
                    o_cmd.with_over = i_item.last_entry;
                end else if (accept && in_wait && (i_item.mode == MODE_TIMEOUT)
                             && retry_again) begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = CMD_OVER;
                end
            end
            default: o_cmd_push = 1'b0;
        endcase
    end

    // transfer state
    always_comb begin
        n_phase   = r_phase;
        n_index   = r_index;
        n_first   = r_first;
        n_count   = r_count;
        n_pkts    = r_pkts;
        n_timeout = r_timeout;
        if (r_state == FS_LOAD) begin
            if (!i_cmd_full) begin
                n_timeout = '0;
                if (ld_done) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_WAIT;
                    n_count = ld_cnt;
                    n_pkts  = ld_pkts;
                end
            end
        end else if (accept) begin
            if (i_item.mode == MODE_START) begin
                n_index = '0;
                n_first = '0;
                n_count = '0;
                n_pkts  = '0;
            end else if (in_wait) begin
                unique case (i_item.mode)
                    MODE_MISSING: n_timeout = '0;
                    MODE_TIMEOUT: n_timeout = tc;
                    default:      n_timeout = '0;
                endcase
                if (go_load) begin
                    n_first = r_first + {16'd0, r_count};
                    n_index = r_index + 17'd1;
                    n_count = '0;
                    n_pkts  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FS_READY;
            r_phase   <= PH_IDLE;
            r_index   <= '0;
            r_first   <= '0;
            r_count   <= '0;
            r_pkts    <= '0;
            r_timeout <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_index   <= n_index;
            r_first   <= n_first;
            r_count   <= n_count;
            r_pkts    <= n_pkts;
            r_timeout <= n_timeout;
        end
    end

endmodule

// ===== rtl/core/bsrc_back.sv =====
`timescale 1ns / 1ps

module bsrc_back #(
    parameter int RECORDS_PER_PACKET = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  bsrc_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output bsrc_pkg::t_result o_result
);
    import bsrc_pkg::*;

    localparam int         PS   = pkt_size(RECORDS_PER_PACKET);
    localparam logic [7:0] PS8  = 8'(PS);

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [3:0]  r_p;
    logic [7:0]  r_off;
    t_result     r_res, n_res;
    logic        r_res_valid;

    logic        slot_free;
    logic        emit;
    logic        last_pkt;
    logic [7:0]  diff;
    logic        is_resend;

    assign slot_free = !r_res_valid || i_pop;
    assign is_resend = (r_cmd.kind == CMD_RESEND);
    assign last_pkt  = (({1'b0, r_p} + 5'd1) == r_cmd.pkts);
    assign diff      = r_cmd.count - r_off;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_FETCH: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_BLAST:  n_state = (i_cmd.pkts != '0) ? BS_DATA : BS_OVER;
                        CMD_OVER:   n_state = BS_OVER;
                        CMD_DONE:   n_state = BS_DONE;
                        CMD_RESEND: n_state = BS_DATA;
                        default:    n_state = BS_FETCH;
                    endcase
                end
            end
            BS_DATA: begin
                if (slot_free) begin
                    if (is_resend) begin
                        n_state = r_cmd.with_over ? BS_OVER : BS_FETCH;
                    end else if (last_pkt) begin
                        n_state = BS_OVER;
                    end
                end
            end
            BS_OVER, BS_DONE: if (slot_free) n_state = BS_FETCH;
            default: n_state = BS_FETCH;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        n_res     = '0;
        unique case (r_state)
            BS_FETCH: o_cmd_pop = i_cmd_valid;
            BS_DATA: begin
                emit                = slot_free;
                n_res.packet_kind   = KIND_DATA;
                n_res.blast_number  = r_cmd.blast;
                n_res.packet_number = r_p;
                n_res.bad_index     = r_cmd.bad;
                n_res.run_last      = is_resend && !r_cmd.with_over;
                if (!r_cmd.bad) begin
                    n_res.first_record      = r_cmd.first + {16'd0, r_off};
                    n_res.records_in_packet = (diff > PS8) ? 5'(PS) : diff[4:0];
                end
            end
            BS_OVER: begin
                emit                = slot_free;
                n_res.packet_kind   = KIND_OVER;
                n_res.blast_number  = r_cmd.blast;
                n_res.packets_total = r_cmd.pkts;
                n_res.run_last      = 1'b1;
            end
            BS_DONE: begin
                emit              = slot_free;
                n_res.packet_kind = KIND_DONE;
                n_res.run_last    = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            if (i_cmd.kind == CMD_RESEND) begin
                r_p   <= i_cmd.idx;
                r_off <= 8'(32'(i_cmd.idx) * PS);
            end else begin
                r_p   <= '0;
                r_off <= '0;
            end
        end else if (emit && (r_state == BS_DATA)) begin
            r_p   <= r_p + 4'd1;
            r_off <= r_off + PS8;
        end
        if (emit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_FETCH;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_empty  = !r_res_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/core/blast_sender_retransmit_control.sv =====
// Blast sender control: turns start, response and timeout events into packet descriptors.
// Events go in through push/full, descriptors come out through empty/pop, oldest first.
// A front end takes one event per cycle when free and turns it into a command; a start or
// blast advance goes through a load state to size the blast. A two-entry command queue
// feeds a back end that fetches a command, then writes one descriptor per cycle into the
// output register while it is free or popped: per blast a data descriptor per packet (up
// to 14) and an over, per missing entry a data descriptor plus an over if last, per
// retried timeout an over. record_total and retry_limit are written through the cfg port;
// the user must write them only while no event is in progress, not enforced by the block.
`timescale 1ns / 1ps

module blast_sender_retransmit_control #(
    parameter int RECORDS_PER_BLAST  = bsrc_pkg::RECORDS_PER_BLAST,
    parameter int RECORDS_PER_PACKET = bsrc_pkg::RECORDS_PER_PACKET,
    parameter int CMD_QUEUE_DEPTH    = bsrc_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  bsrc_pkg::t_item                     i_item,
    output logic                                empty,
    input  logic                                pop,
    output bsrc_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [bsrc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [bsrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bsrc_pkg::*;

    logic [23:0] r_record_total;
    logic [7:0]  r_retry_limit;

    logic        cmd_push;
    logic        cmd_full;
    logic        cmd_empty;
    logic        cmd_pop;
    t_cmd        cmd_in;
    t_cmd        cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_total <= RECORD_TOTAL_RESET;
            r_retry_limit  <= RETRY_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RECORD_TOTAL: r_record_total <= i_cfg_data[23:0];
                CFG_RETRY_LIMIT:  r_retry_limit  <= i_cfg_data[7:0];
                default:          r_retry_limit  <= r_retry_limit;
            endcase
        end
    end

    bsrc_front #(
        .RECORDS_PER_BLAST  (RECORDS_PER_BLAST),
        .RECORDS_PER_PACKET (RECORDS_PER_PACKET)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_item         (i_item),
        .o_full         (full),
        .i_record_total (r_record_total),
        .i_retry_limit  (r_retry_limit),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in),
        .i_cmd_full     (cmd_full)
    );

    bsrc_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    bsrc_back #(
        .RECORDS_PER_PACKET (RECORDS_PER_PACKET)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    a_cmd_no_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cmd_push |-> !cmd_full
    ) else $error("command pushed into a full queue");

    a_done_is_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.packet_kind == KIND_DONE))
            |-> (o_result.run_last && (o_result.blast_number == '0))
    ) else $error("complete descriptor not last or with nonzero blast");

    a_over_total: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.packet_kind == KIND_OVER))
            |-> ((o_result.packets_total != '0)
                 && (o_result.packets_total <= 5'(MAX_DATA_PKTS)))
    ) else $error("blast over with bad packet total");

endmodule
